// File: sv/sensor_range_fault_qualifier_defines.svh
// ---------------------------------------------------------------------------
// sensor_range_fault_qualifier_defines : assertion macros
// Property shorthands for the qualifier checker.
// ---------------------------------------------------------------------------
`ifndef SENSOR_RANGE_FAULT_QUALIFIER_DEFINES_SVH
`define SENSOR_RANGE_FAULT_QUALIFIER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SRFQ_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srfq: same-cycle property failed");

// next-cycle implication, disabled in reset
`define SRFQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srfq: next-cycle property failed");

`endif

// File: sv/srfq_pkg.sv
// ---------------------------------------------------------------------------
// srfq_pkg : sensor range fault qualifier package
// Widths, register map, reset values and qualifier types.
// ---------------------------------------------------------------------------
package srfq_pkg;

	localparam int SampleW  = 12;
	localparam int CountW   = 3;
	localparam int ChanW    = 2;
	localparam int NumChan  = 3;
	localparam int TdataW   = 16;
	localparam int PaddrW   = 5;
	localparam int PdataW   = 32;
	localparam int QuoW     = 7;   // percent result fits below 128
	localparam int NumW     = 19;  // 4095 * 100 fits in 19 bits

	localparam logic [SampleW-1:0] MoistLowRst  = 12'd1000;
	localparam logic [SampleW-1:0] MoistHighRst = 12'd3500;
	localparam logic [SampleW-1:0] LevelLowRst  = 12'd0;
	localparam logic [SampleW-1:0] LevelHighRst = 12'd2300;
	localparam logic [CountW-1:0]  RecheckRst   = 3'd5;
	localparam logic [6:0]         PercentScale = 7'd100;

	localparam logic [2:0] REG_MOIST_LOW  = 3'd0;
	localparam logic [2:0] REG_MOIST_HIGH = 3'd1;
	localparam logic [2:0] REG_LEVEL_LOW  = 3'd2;
	localparam logic [2:0] REG_LEVEL_HIGH = 3'd3;
	localparam logic [2:0] REG_RECHECK    = 3'd4;

	localparam logic [ChanW-1:0] CH_MOIST  = 2'd0;
	localparam logic [ChanW-1:0] CH_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		MODE_NORMAL   = 2'd0,
		MODE_REVISION = 2'd1,
		MODE_FAULT    = 2'd2
	} mode_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [CountW-1:0] cnt;
	} entry_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_EVAL = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage

// File: sv/sensor_range_fault_qualifier.sv
// Sequence: accept, one memory read, one evaluate step, then for a reported moisture
// item seven divider steps for the percent, then the load of the result register.
// Flow: one item in flight; no new item is taken until its result is loaded past any output stall.
// Reset: registers at defaults; all channels normal with countdown zero via
// per-entry valid bits, so the state memory needs no clearing pass.
// ---------------------------------------------------------------------------
// sensor_range_fault_qualifier : range/fault qualifier for three ADC channels
// Per-channel mode and countdown kept in a small synchronous memory,
// read-modify-write per item, percent scaling by a shift-subtract divider.
// ---------------------------------------------------------------------------
module sensor_range_fault_qualifier
	import srfq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// APB configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [PaddrW-1:0] paddr,
	input  logic [PdataW-1:0] pwdata,
	output logic [PdataW-1:0] prdata,
	output logic              pready,
	// input stream
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [TdataW-1:0] s_axis_tdata,  // [11:0] sample, [15:12] zero
	input  logic [ChanW-1:0]  s_axis_tuser,  // [1:0] channel
	// result stream
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [TdataW-1:0] m_axis_tdata,  // [0] report, [12:1] value, [14:13] health, [15] 0
	output logic [ChanW-1:0]  m_axis_tuser   // [1:0] channel_out
);

	// configuration registers
	logic [SampleW-1:0] moist_low_q, moist_high_q, level_low_q, level_high_q;
	logic [CountW-1:0]  recheck_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moist_low_q  <= MoistLowRst;
			moist_high_q <= MoistHighRst;
			level_low_q  <= LevelLowRst;
			level_high_q <= LevelHighRst;
			recheck_q    <= RecheckRst;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_MOIST_LOW:  moist_low_q  <= pwdata[SampleW-1:0];
				REG_MOIST_HIGH: moist_high_q <= pwdata[SampleW-1:0];
				REG_LEVEL_LOW:  level_low_q  <= pwdata[SampleW-1:0];
				REG_LEVEL_HIGH: level_high_q <= pwdata[SampleW-1:0];
				REG_RECHECK:    recheck_q    <= pwdata[CountW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_MOIST_LOW:  prdata = PdataW'(moist_low_q);
			REG_MOIST_HIGH: prdata = PdataW'(moist_high_q);
			REG_LEVEL_LOW:  prdata = PdataW'(level_low_q);
			REG_LEVEL_HIGH: prdata = PdataW'(level_high_q);
			REG_RECHECK:    prdata = PdataW'(recheck_q);
			default:        prdata = '0;
		endcase
	end

	// control and item registers
	state_t             state_q;
	logic [ChanW-1:0]   ch_q;
	logic [SampleW-1:0] smp_q;

	// state memory and valid bits
	entry_t             mem [NumChan];
	logic [NumChan-1:0] vld_q;
	entry_t             ent_q;
	logic               ent_vld_q;
	logic               mem_we;
	entry_t             ent_new;

	// divider
	logic [NumW-1:0]    rem_q;
	logic [SampleW-1:0] span_q;
	logic [2:0]         step_q;
	logic [QuoW-1:0]    quo_q;
	logic [NumW-1:0]    dvs;

	// pending result
	logic               res_rep_q;
	logic [SampleW-1:0] res_val_q;
	logic [1:0]         res_hlth_q;

	// output register
	logic               out_vld_q;
	logic [TdataW-1:0]  out_data_q;
	logic [ChanW-1:0]   out_user_q;
	logic               out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign out_load      = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);

	// evaluate step
	logic [SampleW-1:0] lo, hi, span, diff;
	logic               in_rng;
	entry_t             cur;
	logic               rep;

	always_comb begin
		lo     = (ch_q == CH_MOIST) ? moist_low_q  : level_low_q;
		hi     = (ch_q == CH_MOIST) ? moist_high_q : level_high_q;
		in_rng = (smp_q >= lo) && (smp_q <= hi);
		span   = moist_high_q - moist_low_q;
		diff   = moist_high_q - smp_q;
		cur    = ent_vld_q ? ent_q : entry_t'('0);
		ent_new = cur;
		rep    = 1'b0;
		unique case (cur.mode)
			MODE_NORMAL: begin
				if (in_rng) begin
					rep = 1'b1;
				end else begin
					ent_new.mode = MODE_REVISION;
					ent_new.cnt  = recheck_q;
				end
			end
			MODE_REVISION: begin
				if (cur.cnt != '0) begin
					ent_new.cnt = cur.cnt - 1'b1;
				end else if (in_rng) begin
					ent_new.mode = MODE_NORMAL;
				end else begin
					ent_new.mode = MODE_FAULT;
				end
			end
			MODE_FAULT: begin
				if (in_rng) begin
					ent_new.mode = MODE_REVISION;
					ent_new.cnt  = recheck_q;
				end
			end
			default: begin
				ent_new.mode = MODE_NORMAL;
				ent_new.cnt  = '0;
			end
		endcase
		mem_we = (state_q == ST_EVAL) && (ch_q != CH_UNUSED);
	end

	assign dvs = NumW'(span_q) << step_q;

	// memory: read in READ, written back in EVAL; one item in flight, no overlap
	always_ff @(posedge clk) begin
		if (state_q == ST_READ && ch_q != CH_UNUSED) begin
			ent_q <= mem[ch_q];
		end
		if (mem_we) begin
			mem[ch_q] <= ent_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			ent_vld_q <= 1'b0;
		end else begin
			if (state_q == ST_READ) begin
				ent_vld_q <= (ch_q != CH_UNUSED) && vld_q[ch_q];
			end
			if (mem_we) begin
				vld_q[ch_q] <= 1'b1;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid) state_q <= ST_READ;
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: begin
					if (ch_q == CH_MOIST && rep && span != '0) state_q <= ST_DIV;
					else state_q <= ST_DONE;
				end
				ST_DIV:  if (step_q == '0) state_q <= ST_DONE;
				ST_DONE: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item, divider and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			ch_q  <= s_axis_tuser;
			smp_q <= s_axis_tdata[SampleW-1:0];
		end
		if (state_q == ST_EVAL) begin
			res_rep_q  <= rep && (ch_q != CH_UNUSED);
			res_hlth_q <= (ch_q == CH_UNUSED) ? MODE_NORMAL : ent_new.mode;
			// tanks report raw; zero moisture span reports 0
			res_val_q  <= (rep && ch_q != CH_UNUSED && ch_q != CH_MOIST) ? smp_q : '0;
			rem_q      <= NumW'(diff) * NumW'(PercentScale);
			span_q     <= span;
			step_q     <= 3'(QuoW - 1);
			quo_q      <= '0;
		end
		if (state_q == ST_DIV) begin
			if (rem_q >= dvs) begin
				rem_q         <= rem_q - dvs;
				quo_q[step_q] <= 1'b1;
			end
			step_q <= step_q - 1'b1;
		end
		if (state_q == ST_DIV && step_q == '0) begin
			res_val_q <= SampleW'({quo_q[QuoW-1:1], rem_q >= dvs});
		end
		if (out_load) begin
			out_data_q <= {1'b0, res_hlth_q, res_val_q, res_rep_q};
			out_user_q <= ch_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

endmodule

// File: sv/srfq_checker.sv
// ---------------------------------------------------------------------------
// srfq_checker : result stream checks for the qualifier
// Watches the top-level result port; bound to every instance.
// ---------------------------------------------------------------------------
`include "sensor_range_fault_qualifier_defines.svh"

module srfq_checker
	import srfq_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [TdataW-1:0] m_axis_tdata,
	input logic [ChanW-1:0]  m_axis_tuser
);

	// stalled result holds
	`SRFQ_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
	// no report, no value
	`SRFQ_ASSERT_IMPL(a_val_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[12:1] == '0)
	// a report only comes from a normal channel
	`SRFQ_ASSERT_IMPL(a_rep_norm, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[14:13] == MODE_NORMAL)
	// unused channel is inert
	`SRFQ_ASSERT_IMPL(a_unused, m_axis_tvalid && m_axis_tuser == CH_UNUSED, !m_axis_tdata[0] && m_axis_tdata[14:13] == MODE_NORMAL)
	// moisture percent never exceeds full scale
	`SRFQ_ASSERT_IMPL(a_pct, m_axis_tvalid && m_axis_tuser == CH_MOIST, m_axis_tdata[12:1] <= 12'd100)

endmodule

bind sensor_range_fault_qualifier srfq_checker u_srfq_checker (.*);
